FILE: rtl/b64lw_pkg.sv
package b64lw_pkg;

    localparam int GPL_W = 6;
    localparam logic [GPL_W-1:0] GPL_RESET = 6'd19;

    // bytes already taken of the current group
    localparam logic [1:0] PH_ZERO = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    localparam logic [7:0] CH_PAD = 8'h3D;  // '='
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // up to four characters caused by one input word
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;  // index of the final character
        logic            done;      // final character closes the message
    } t_grp;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      return 8'h41 + w;
        else if (v < 6'd52) return 8'h61 + (w - 8'd26);
        else if (v < 6'd62) return 8'h30 + (w - 8'd52);
        else if (v == 6'd62) return 8'h2B;
        else                return 8'h2F;
    endfunction

endpackage

FILE: rtl/b64lw_encode.sv
module b64lw_encode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_message_end,
    output logic               o_pend_vld,
    output b64lw_pkg::t_grp    o_pend,
    input  logic               i_take
);
    import b64lw_pkg::*;

    logic [GPL_W-1:0] r_gpl;
    logic [1:0]       r_phase, n_phase;
    logic [3:0]       r_carry, n_carry;
    logic [GPL_W-1:0] r_line,  n_line;
    logic             r_pend_vld;
    t_grp             r_pend,  n_pend;
    logic [GPL_W-1:0] line_inc;
    logic             accept;

    assign o_stall    = r_pend_vld && !i_take;
    assign accept     = i_valid && !o_stall;
    assign o_pend_vld = r_pend_vld;
    assign o_pend     = r_pend;
    assign line_inc   = r_line + 6'd1;

    always_comb begin
        n_pend.chars    = '0;
        n_pend.last_idx = 2'd0;
        n_pend.done     = i_message_end;
        n_phase         = r_phase;
        n_carry         = r_carry;
        n_line          = r_line;
        case (r_phase)
            PH_ONE: begin
                n_pend.chars[0] = b64_char({r_carry[1:0], i_data_byte[7:4]});
                n_carry = i_data_byte[3:0];
                n_phase = PH_TWO;
                if (i_message_end) begin
                    n_pend.chars[1] = b64_char({i_data_byte[3:0], 2'b00});
                    n_pend.chars[2] = CH_PAD;
                    n_pend.last_idx = 2'd2;
                end
            end
            PH_TWO: begin
                n_pend.chars[0] = b64_char({r_carry, i_data_byte[7:6]});
                n_pend.chars[1] = b64_char(i_data_byte[5:0]);
                n_pend.last_idx = 2'd1;
                n_carry = 4'd0;
                n_phase = PH_ZERO;
                n_line  = line_inc;
                if (line_inc == r_gpl) begin
                    n_pend.chars[2] = CH_CR;
                    n_pend.chars[3] = CH_LF;
                    n_pend.last_idx = 2'd3;
                    n_line = '0;
                end
            end
            default: begin
                n_pend.chars[0] = b64_char(i_data_byte[7:2]);
                n_carry = {2'b00, i_data_byte[1:0]};
                n_phase = PH_ONE;
                if (i_message_end) begin
                    n_pend.chars[1] = b64_char({i_data_byte[1:0], 4'b0000});
                    n_pend.chars[2] = CH_PAD;
                    n_pend.chars[3] = CH_PAD;
                    n_pend.last_idx = 2'd3;
                end
            end
        endcase
        if (i_message_end) begin
            n_phase = PH_ZERO;
            n_carry = 4'd0;
            n_line  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl      <= GPL_RESET;
            r_phase    <= PH_ZERO;
            r_carry    <= 4'd0;
            r_line     <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gpl <= i_cfg_data;
            end
            if (accept) begin
                r_phase    <= n_phase;
                r_carry    <= n_carry;
                r_line     <= n_line;
                r_pend_vld <= 1'b1;
            end else if (i_take) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

`ifndef ASSERT_OFF
    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld && !i_take |=> r_pend_vld && $stable(r_pend))
        else $error("pending group lost or changed");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_message_end |=> r_phase == PH_ZERO && r_carry == 4'd0 && r_line == '0)
        else $error("state not cleared after message end");
    a_phase_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("unused group phase reached");
`endif

endmodule

FILE: rtl/b64lw_serial.sv
module b64lw_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pend_vld,
    input  b64lw_pkg::t_grp    i_pend,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_char,
    output logic               o_run_last,
    output logic               o_message_done
);
    import b64lw_pkg::*;

    logic       r_cur_vld;
    t_grp       r_cur;
    logic [1:0] r_idx;
    logic       fire, at_last, free;

    assign fire    = r_cur_vld && !i_stall;
    assign at_last = (r_idx == r_cur.last_idx);
    assign free    = !r_cur_vld || (fire && at_last);
    assign o_take  = free && i_pend_vld;

    assign o_valid        = r_cur_vld;
    assign o_out_char     = r_cur.chars[r_idx];
    assign o_run_last     = at_last;
    assign o_message_done = at_last && r_cur.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_idx     <= 2'd0;
        end else if (o_take) begin
            r_cur_vld <= 1'b1;
            r_idx     <= 2'd0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
            if (at_last) begin
                r_cur_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cur <= i_pend;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_vld |-> r_idx <= r_cur.last_idx)
        else $error("character index past end of group");
    a_mid_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !at_last |=> r_cur_vld && r_idx == $past(r_idx) + 2'd1)
        else $error("group cut short");
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_cur_vld && r_idx == 2'd0)
        else $error("new group not started at first character");
`endif

endmodule

FILE: rtl/base64_encoder_line_wrap_unit.sv
// Base64 encoder with CR LF line wrap after a configurable number of groups.
// The first character of a word passes the encode result register and then the
// serializer's group register before it is valid. Throughput: one character
// per cycle while i_stall is low; a word gives 1 to 4 characters; input words
// are taken back to back while the output keeps up with one character per word.
// Reset (synchronous, i_rst_n low): encoder state cleared, groups_per_line = 19.
module base64_encoder_line_wrap_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: groups_per_line
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data,
    // input words
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_message_end,
    // output characters
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_message_done
);
    import b64lw_pkg::*;

    t_grp pend;
    logic pend_vld;
    logic take;

    // The user must make register writes only while idle; the block does not enforce this, and writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Encode stage: turns each accepted word into its group of up to four
    // characters (sextets, padding, CR LF) and updates the group state.
    // Its result register frees up as the serializer pulls it, so the next
    // word is accepted while the previous one is still being sent.
    b64lw_encode u_encode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .o_pend_vld    (pend_vld),
        .o_pend        (pend),
        .i_take        (take)
    );

    // Serializer: one character per cycle while i_stall is low, loads the next group on the
    // cycle its last character leaves, so pending groups follow with no gap.
    b64lw_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pend_vld     (pend_vld),
        .i_pend         (pend),
        .o_take         (take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_run_last     (o_run_last),
        .o_message_done (o_message_done)
    );

endmodule
